### hw/rtl/bgi_pkg.sv
// bgi_pkg: shared constants, state type and saturation helper for the
// biquadratic grid interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

    // grid dimensions
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 128;
    localparam int MIN_COLS    = 3;
    localparam int MIN_ROWS    = 2;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = 14;
    localparam int COL_IDX_W   = $clog2(MAX_COLS);
    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int DIM_W       = 8;

    // number formats
    localparam int COORD_W = 32;
    localparam int FRAC    = 16;
    localparam int HALF_Q  = 32768;
    localparam int GRID_W  = 49;                 // grid-unit coordinate, q33.16
    localparam int LOC_W   = GRID_W + 1 - FRAC;  // cell index before range check
    localparam int T_W     = 16;                 // offset from cell centre
    localparam int A_W     = 35;                 // quadratic coefficients
    localparam int B_W     = COORD_W + 1;        // second multiplier operand
    localparam int PROD_W  = A_W + B_W;
    localparam int ACC_W   = 36;                 // sums before saturation

    // stream layout
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_ADDR_W  = 5;

    // register map, index is paddr[4:2]
    localparam logic [2:0] REG_R_ORIGIN   = 3'd0;
    localparam logic [2:0] REG_Z_ORIGIN   = 3'd1;
    localparam logic [2:0] REG_R_INV_STEP = 3'd2;
    localparam logic [2:0] REG_Z_INV_STEP = 3'd3;
    localparam logic [2:0] REG_GRID_COLS  = 3'd4;
    localparam logic [2:0] REG_GRID_ROWS  = 3'd5;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // component selection
    localparam logic [1:0] PICK_VALUE   = 2'd0;
    localparam logic [1:0] PICK_DERIV_Z = 2'd1;
    localparam logic [1:0] PICK_DERIV_R = 2'd2;

    // sample read order within one column
    localparam logic [1:0] ROW_DN  = 2'd0;
    localparam logic [1:0] ROW_MID = 2'd1;
    localparam logic [1:0] ROW_UP  = 2'd2;
    localparam logic [1:0] COL_LAST = 2'd2;

    localparam logic [3:0] READ_ISSUES = 4'd9;
    localparam logic [3:0] READ_LAST   = 4'd9;

    // fit phases: three columns, then across for value, then across for slope
    localparam logic [2:0] PHASE_COL_LAST   = 3'd2;
    localparam logic [2:0] PHASE_ACROSS_VAL = 3'd3;
    localparam logic [2:0] PHASE_LAST       = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_R,
        ST_MAP_Z,
        ST_LOCATE,
        ST_BASE,
        ST_READ,
        ST_FIT_SETUP,
        ST_FIT_MUL1,
        ST_FIT_MUL2,
        ST_FIT_SUM,
        ST_DONE
    } state_t;

    // clamp to the signed 32 bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((v[ACC_W-1:COORD_W-1] == '0) || (v[ACC_W-1:COORD_W-1] == '1))
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/biquadratic_grid_interpolator.sv
// biquadratic_grid_interpolator: top level with sample store, sequencer and
// one shared multiplier
// depends on bgi_pkg
`timescale 1ns / 1ps
`default_nettype none

// Stores a grid of Q16.16 samples and answers interpolation queries with the
// value and both derivatives in grid units. A write transaction (tuser op 0)
// stores one sample and gives no result. A query transaction (tuser op 1) maps
// r/z into grid units, reads the nine neighbouring samples (six are used on
// row zero) from a single-port store, fits a quadratic down each of three
// columns and then across them. All multiplies go through one 35x33 signed
// multiplier and the samples through the one memory port, so a query keeps
// the input closed until its result is registered for output; a query outside
// the valid cells skips the reads. The result sits in an output register, so a
// new transaction is taken while an earlier result still waits. Reading a
// sample never written is not defined. The user must write configuration
// through the apb port only while idle; the block itself does not enforce it.
module biquadratic_grid_interpolator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // address[13:0], sample[45:14], r_coord[77:46], z_coord[109:78],
    // pick[111:110], tag[127:112]
    input  wire logic [bgi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                        s_axis_tuser,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // value[31:0], deriv_z[63:32], deriv_r[95:64], picked[127:96],
    // tag_out[143:128]
    output logic [bgi_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]                             m_axis_tuser,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bgi_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int CW = bgi_pkg::COORD_W;

    // ---------------------------------------------------------------- fields
    logic                               in_op;
    logic [bgi_pkg::ADDR_W-1:0]         in_address;
    logic signed [CW-1:0]               in_sample;
    logic signed [CW-1:0]               in_r_coord;
    logic signed [CW-1:0]               in_z_coord;
    logic [1:0]                         in_pick;
    logic [15:0]                        in_tag;

    assign in_op      = s_axis_tuser[0];
    assign in_address = s_axis_tdata[13:0];
    assign in_sample  = s_axis_tdata[45:14];
    assign in_r_coord = s_axis_tdata[77:46];
    assign in_z_coord = s_axis_tdata[109:78];
    assign in_pick    = s_axis_tdata[111:110];
    assign in_tag     = s_axis_tdata[127:112];

    // ------------------------------------------------------- configuration
    logic signed [CW-1:0]               r_origin_reg;
    logic signed [CW-1:0]               z_origin_reg;
    logic [CW-1:0]                      r_inv_step_reg;
    logic [CW-1:0]                      z_inv_step_reg;
    logic [bgi_pkg::DIM_W-1:0]          grid_cols_reg;
    logic [bgi_pkg::DIM_W-1:0]          grid_rows_reg;
    logic                               cfg_write;
    logic [2:0]                         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[bgi_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_origin_reg   <= '0;
            z_origin_reg   <= '0;
            r_inv_step_reg <= 32'd65536;
            z_inv_step_reg <= 32'd65536;
            grid_cols_reg  <= bgi_pkg::DIM_W'(bgi_pkg::MAX_COLS);
            grid_rows_reg  <= bgi_pkg::DIM_W'(bgi_pkg::MAX_ROWS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bgi_pkg::REG_R_ORIGIN:   r_origin_reg   <= pwdata;
                bgi_pkg::REG_Z_ORIGIN:   z_origin_reg   <= pwdata;
                bgi_pkg::REG_R_INV_STEP: r_inv_step_reg <= pwdata;
                bgi_pkg::REG_Z_INV_STEP: z_inv_step_reg <= pwdata;
                bgi_pkg::REG_GRID_COLS:  grid_cols_reg  <= pwdata[bgi_pkg::DIM_W-1:0];
                bgi_pkg::REG_GRID_ROWS:  grid_rows_reg  <= pwdata[bgi_pkg::DIM_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            bgi_pkg::REG_R_ORIGIN:   prdata = r_origin_reg;
            bgi_pkg::REG_Z_ORIGIN:   prdata = z_origin_reg;
            bgi_pkg::REG_R_INV_STEP: prdata = r_inv_step_reg;
            bgi_pkg::REG_Z_INV_STEP: prdata = z_inv_step_reg;
            bgi_pkg::REG_GRID_COLS:  prdata = {{(32-bgi_pkg::DIM_W){1'b0}}, grid_cols_reg};
            bgi_pkg::REG_GRID_ROWS:  prdata = {{(32-bgi_pkg::DIM_W){1'b0}}, grid_rows_reg};
            default:                 prdata = '0;
        endcase
    end

    // grid size as used: columns clamped to [3, max], rows to [2, max]
    logic [bgi_pkg::DIM_W-1:0]          cols_eff;
    logic [bgi_pkg::DIM_W-1:0]          rows_eff;
    logic [bgi_pkg::DIM_W-1:0]          cols_m2;
    logic [bgi_pkg::DIM_W-1:0]          rows_m1;

    always_comb
    begin
        if (grid_cols_reg < bgi_pkg::DIM_W'(bgi_pkg::MIN_COLS))
        begin
            cols_eff = bgi_pkg::DIM_W'(bgi_pkg::MIN_COLS);
        end
        else if (grid_cols_reg > bgi_pkg::DIM_W'(bgi_pkg::MAX_COLS))
        begin
            cols_eff = bgi_pkg::DIM_W'(bgi_pkg::MAX_COLS);
        end
        else
        begin
            cols_eff = grid_cols_reg;
        end

        if (grid_rows_reg < bgi_pkg::DIM_W'(bgi_pkg::MIN_ROWS))
        begin
            rows_eff = bgi_pkg::DIM_W'(bgi_pkg::MIN_ROWS);
        end
        else if (grid_rows_reg > bgi_pkg::DIM_W'(bgi_pkg::MAX_ROWS))
        begin
            rows_eff = bgi_pkg::DIM_W'(bgi_pkg::MAX_ROWS);
        end
        else
        begin
            rows_eff = grid_rows_reg;
        end

        cols_m2 = cols_eff - bgi_pkg::DIM_W'(2);
        rows_m1 = rows_eff - bgi_pkg::DIM_W'(1);
    end

    // ----------------------------------------------------------- sequencer
    bgi_pkg::state_t                    state_reg;
    bgi_pkg::state_t                    state_next;
    logic [3:0]                         cnt_reg;
    logic [3:0]                         cnt_next;
    logic [1:0]                         rrow_reg;
    logic [1:0]                         rrow_next;
    logic [1:0]                         rcol_reg;
    logic [1:0]                         rcol_next;
    logic [2:0]                         phase_reg;
    logic [2:0]                         phase_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    logic                               in_accept;
    logic                               mem_we;
    logic                               read_issue;
    logic                               read_capture;
    logic                               mul_load;
    logic                               out_load;
    logic                               loc_oor;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign mem_we    = in_accept && (in_op == bgi_pkg::OP_WRITE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgi_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && (in_op == bgi_pkg::OP_QUERY))
                begin
                    state_next = bgi_pkg::ST_MAP_R;
                end
            end
            bgi_pkg::ST_MAP_R:     state_next = bgi_pkg::ST_MAP_Z;
            bgi_pkg::ST_MAP_Z:     state_next = bgi_pkg::ST_LOCATE;
            bgi_pkg::ST_LOCATE:
            begin
                state_next = loc_oor ? bgi_pkg::ST_DONE : bgi_pkg::ST_BASE;
            end
            bgi_pkg::ST_BASE:      state_next = bgi_pkg::ST_READ;
            bgi_pkg::ST_READ:
            begin
                if (cnt_reg == bgi_pkg::READ_LAST)
                begin
                    state_next = bgi_pkg::ST_FIT_SETUP;
                end
            end
            bgi_pkg::ST_FIT_SETUP: state_next = bgi_pkg::ST_FIT_MUL1;
            bgi_pkg::ST_FIT_MUL1:  state_next = bgi_pkg::ST_FIT_MUL2;
            bgi_pkg::ST_FIT_MUL2:  state_next = bgi_pkg::ST_FIT_SUM;
            bgi_pkg::ST_FIT_SUM:
            begin
                state_next = (phase_reg == bgi_pkg::PHASE_LAST) ? bgi_pkg::ST_DONE
                                                                : bgi_pkg::ST_FIT_SETUP;
            end
            bgi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = bgi_pkg::ST_IDLE;
                end
            end
            default:               state_next = bgi_pkg::ST_IDLE;
        endcase
    end

    // control outputs and counters
    always_comb
    begin
        s_axis_tready = 1'b0;
        read_issue    = 1'b0;
        read_capture  = 1'b0;
        mul_load      = 1'b0;
        out_load      = 1'b0;
        cnt_next      = cnt_reg;
        rrow_next     = rrow_reg;
        rcol_next     = rcol_reg;
        phase_next    = phase_reg;
        unique case (state_reg)
            bgi_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            bgi_pkg::ST_MAP_R, bgi_pkg::ST_MAP_Z,
            bgi_pkg::ST_FIT_MUL1, bgi_pkg::ST_FIT_MUL2:
            begin
                mul_load = 1'b1;
            end
            bgi_pkg::ST_BASE:
            begin
                cnt_next   = '0;
                rrow_next  = bgi_pkg::ROW_DN;
                rcol_next  = '0;
                phase_next = '0;
            end
            bgi_pkg::ST_READ:
            begin
                read_issue   = (cnt_reg < bgi_pkg::READ_ISSUES);
                read_capture = (cnt_reg != '0);
                cnt_next     = cnt_reg + 4'd1;
                if (read_issue)
                begin
                    if (rrow_reg == bgi_pkg::ROW_UP)
                    begin
                        rrow_next = bgi_pkg::ROW_DN;
                        rcol_next = rcol_reg + 2'd1;
                    end
                    else
                    begin
                        rrow_next = rrow_reg + 2'd1;
                    end
                end
            end
            bgi_pkg::ST_FIT_SUM:
            begin
                phase_next = phase_reg + 3'd1;
            end
            bgi_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgi_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rrow_reg      <= bgi_pkg::ROW_DN;
            rcol_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rrow_reg      <= rrow_next;
            rcol_reg      <= rcol_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------- query capture
    logic signed [CW-1:0]               r_coord_reg;
    logic signed [CW-1:0]               z_coord_reg;
    logic [1:0]                         pick_reg;
    logic [15:0]                        tag_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            r_coord_reg <= in_r_coord;
            z_coord_reg <= in_z_coord;
            pick_reg    <= in_pick;
            tag_reg     <= in_tag;
        end
    end

    // ------------------------------------------------------ shared multiplier
    logic signed [CW:0]                 r_diff;
    logic signed [CW:0]                 z_diff;
    logic signed [bgi_pkg::A_W-1:0]     mul_a;
    logic signed [bgi_pkg::B_W-1:0]     mul_b;
    logic signed [bgi_pkg::PROD_W-1:0]  mul_p;
    logic signed [bgi_pkg::PROD_W-1:0]  prod_reg;
    logic signed [bgi_pkg::ACC_W-1:0]   p1;
    logic signed [bgi_pkg::ACC_W-1:0]   u_full;

    logic signed [bgi_pkg::A_W-1:0]     a1_reg;
    logic signed [bgi_pkg::A_W-1:0]     a2_reg;
    logic signed [CW-1:0]               addend_reg;
    logic signed [bgi_pkg::T_W-1:0]     t_reg;
    logic signed [bgi_pkg::ACC_W-1:0]   p1_reg;

    assign r_diff = (CW+1)'(r_coord_reg) - (CW+1)'(r_origin_reg);
    assign z_diff = (CW+1)'(z_coord_reg) - (CW+1)'(z_origin_reg);

    // first product scaled by 2^-16, then plus a2 for the second multiply
    assign p1     = prod_reg[bgi_pkg::ACC_W+bgi_pkg::FRAC-1:bgi_pkg::FRAC];
    assign u_full = p1 + bgi_pkg::ACC_W'(a2_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            bgi_pkg::ST_MAP_R:
            begin
                mul_a = bgi_pkg::A_W'(r_diff);
                mul_b = $signed({1'b0, r_inv_step_reg});
            end
            bgi_pkg::ST_MAP_Z:
            begin
                mul_a = bgi_pkg::A_W'(z_diff);
                mul_b = $signed({1'b0, z_inv_step_reg});
            end
            bgi_pkg::ST_FIT_MUL1:
            begin
                mul_a = a1_reg;
                mul_b = bgi_pkg::B_W'(t_reg);
            end
            bgi_pkg::ST_FIT_MUL2:
            begin
                mul_a = u_full[bgi_pkg::A_W-1:0];
                mul_b = bgi_pkg::B_W'(t_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = bgi_pkg::PROD_W'(mul_a) * bgi_pkg::PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            prod_reg <= mul_p;
        end
    end

    // ----------------------------------------------- locate the cell
    logic signed [bgi_pkg::GRID_W-1:0]  x_reg;
    logic signed [bgi_pkg::GRID_W-1:0]  y_grid;
    logic signed [bgi_pkg::GRID_W:0]    x_shift;
    logic signed [bgi_pkg::GRID_W:0]    y_shift;
    logic signed [bgi_pkg::LOC_W-1:0]   m_loc;
    logic signed [bgi_pkg::LOC_W-1:0]   n_loc;
    logic signed [bgi_pkg::T_W-1:0]     dx_reg;
    logic signed [bgi_pkg::T_W-1:0]     dy_reg;
    logic [bgi_pkg::COL_IDX_W-1:0]      m_reg;
    logic [bgi_pkg::ROW_IDX_W-1:0]      n_reg;
    logic                               row0_reg;
    logic                               oor_reg;

    assign y_grid  = prod_reg[bgi_pkg::FRAC+bgi_pkg::GRID_W-1:bgi_pkg::FRAC];
    // column index uses x - 1/2, row index y + 1/2, both floored
    assign x_shift = (bgi_pkg::GRID_W+1)'(x_reg) - (bgi_pkg::GRID_W+1)'(bgi_pkg::HALF_Q);
    assign y_shift = (bgi_pkg::GRID_W+1)'(y_grid) + (bgi_pkg::GRID_W+1)'(bgi_pkg::HALF_Q);
    assign m_loc   = x_shift[bgi_pkg::GRID_W:bgi_pkg::FRAC];
    assign n_loc   = y_shift[bgi_pkg::GRID_W:bgi_pkg::FRAC];

    assign loc_oor = m_loc[bgi_pkg::LOC_W-1] || n_loc[bgi_pkg::LOC_W-1]
                  || (m_loc >= $signed({{(bgi_pkg::LOC_W-bgi_pkg::DIM_W){1'b0}}, cols_m2}))
                  || (n_loc >= $signed({{(bgi_pkg::LOC_W-bgi_pkg::DIM_W){1'b0}}, rows_m1}));

    always_ff @(posedge clk)
    begin
        if (state_reg == bgi_pkg::ST_MAP_Z)
        begin
            x_reg <= prod_reg[bgi_pkg::FRAC+bgi_pkg::GRID_W-1:bgi_pkg::FRAC];
        end
        if (state_reg == bgi_pkg::ST_LOCATE)
        begin
            // offset from the nearest centre is the low half taken as signed
            dx_reg   <= x_reg[bgi_pkg::T_W-1:0];
            dy_reg   <= y_grid[bgi_pkg::T_W-1:0];
            m_reg    <= m_loc[bgi_pkg::COL_IDX_W-1:0];
            n_reg    <= n_loc[bgi_pkg::ROW_IDX_W-1:0];
            row0_reg <= (n_loc == '0);
            oor_reg  <= loc_oor;
        end
    end

    // ----------------------------------------------------- sample store
    localparam int RS_W = bgi_pkg::ROW_IDX_W + bgi_pkg::DIM_W;

    logic [RS_W-1:0]                    row_start;
    logic [bgi_pkg::ADDR_W-1:0]         base_reg;
    logic [bgi_pkg::ADDR_W-1:0]         col_addr;
    logic [bgi_pkg::ADDR_W-1:0]         cols_ext;
    logic [bgi_pkg::ADDR_W-1:0]         rd_addr;
    logic [bgi_pkg::ADDR_W-1:0]         mem_addr;
    logic signed [CW-1:0]               grid_mem [0:bgi_pkg::STORE_DEPTH-1];
    logic signed [CW-1:0]               mem_rdata_reg;

    assign row_start = RS_W'(n_reg) * RS_W'(cols_eff);
    assign cols_ext  = bgi_pkg::ADDR_W'(cols_eff);
    assign col_addr  = base_reg + bgi_pkg::ADDR_W'(rcol_reg);

    // the row below wraps on row zero, its sample is then unused
    always_comb
    begin
        case (rrow_reg)
            bgi_pkg::ROW_DN:  rd_addr = col_addr - cols_ext;
            bgi_pkg::ROW_UP:  rd_addr = col_addr + cols_ext;
            default:          rd_addr = col_addr;
        endcase
    end

    assign mem_addr = (state_reg == bgi_pkg::ST_IDLE) ? in_address : rd_addr;

    always_ff @(posedge clk)
    begin
        if (state_reg == bgi_pkg::ST_BASE)
        begin
            base_reg <= bgi_pkg::ADDR_W'(row_start) + bgi_pkg::ADDR_W'(m_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= in_sample;
        end
        mem_rdata_reg <= grid_mem[mem_addr];
    end

    // ---------------------------------------- neighbourhood and fit results
    // samples arrive below, centre, above per column, columns left to right
    logic signed [CW-1:0]               samp_reg [0:8];
    logic signed [CW-1:0]               af_reg [0:2];
    logic signed [CW-1:0]               adf_reg [0:2];
    logic signed [CW-1:0]               w_value_reg;
    logic signed [CW-1:0]               w_dz_reg;
    logic signed [CW-1:0]               w_dr_reg;

    logic signed [CW-1:0]               src_up;
    logic signed [CW-1:0]               src_mid;
    logic signed [CW-1:0]               src_dn;
    logic                               col_phase;
    logic                               use_row0;
    logic signed [bgi_pkg::A_W-1:0]     a1_fit;
    logic signed [bgi_pkg::A_W-1:0]     a2_fit;

    logic signed [bgi_pkg::ACC_W-1:0]   q_term;
    logic signed [bgi_pkg::ACC_W-1:0]   val_sum;
    logic signed [bgi_pkg::ACC_W-1:0]   slope_sum;
    logic signed [CW-1:0]               val_sat;
    logic signed [CW-1:0]               slope_sat;

    assign col_phase = (phase_reg <= bgi_pkg::PHASE_COL_LAST);
    assign use_row0  = col_phase && row0_reg;

    always_comb
    begin
        if (col_phase)
        begin
            src_up  = samp_reg[2];
            src_mid = samp_reg[1];
            src_dn  = samp_reg[0];
        end
        else if (phase_reg == bgi_pkg::PHASE_ACROSS_VAL)
        begin
            src_up  = af_reg[2];
            src_mid = af_reg[1];
            src_dn  = af_reg[0];
        end
        else
        begin
            src_up  = adf_reg[2];
            src_mid = adf_reg[1];
            src_dn  = adf_reg[0];
        end

        // row zero: mirrored one-sided form
        if (use_row0)
        begin
            a1_fit = (bgi_pkg::A_W'(src_up) - bgi_pkg::A_W'(src_mid)) <<< 1;
            a2_fit = '0;
        end
        else
        begin
            a1_fit = bgi_pkg::A_W'(src_up) + bgi_pkg::A_W'(src_dn)
                   - (bgi_pkg::A_W'(src_mid) <<< 1);
            a2_fit = bgi_pkg::A_W'(src_up) - bgi_pkg::A_W'(src_dn);
        end
    end

    // value: (a1*t/2^16 + a2)*t/2^17 + a1/8 + centre, slope: a1*t/2^16 + a2/2
    assign q_term    = prod_reg[bgi_pkg::ACC_W+bgi_pkg::FRAC:bgi_pkg::FRAC+1];
    assign val_sum   = q_term + bgi_pkg::ACC_W'(a1_reg >>> 3) + bgi_pkg::ACC_W'(addend_reg);
    assign slope_sum = p1_reg + bgi_pkg::ACC_W'(a2_reg >>> 1);
    assign val_sat   = bgi_pkg::sat32(val_sum);
    assign slope_sat = bgi_pkg::sat32(slope_sum);

    always_ff @(posedge clk)
    begin
        if (read_capture)
        begin
            for (int k = 0; k < 8; k++)
            begin
                samp_reg[k] <= samp_reg[k+1];
            end
            samp_reg[8] <= mem_rdata_reg;
        end

        if (state_reg == bgi_pkg::ST_FIT_SETUP)
        begin
            a1_reg     <= a1_fit;
            a2_reg     <= a2_fit;
            addend_reg <= src_mid;
            t_reg      <= col_phase ? dy_reg : dx_reg;
        end

        if (state_reg == bgi_pkg::ST_FIT_MUL2)
        begin
            p1_reg <= p1;
        end

        if (state_reg == bgi_pkg::ST_FIT_SUM)
        begin
            if (col_phase)
            begin
                // move the next column to the head
                for (int k = 0; k < 6; k++)
                begin
                    samp_reg[k] <= samp_reg[k+3];
                end
                af_reg[0]  <= af_reg[1];
                af_reg[1]  <= af_reg[2];
                af_reg[2]  <= val_sat;
                adf_reg[0] <= adf_reg[1];
                adf_reg[1] <= adf_reg[2];
                adf_reg[2] <= slope_sat;
            end
            else if (phase_reg == bgi_pkg::PHASE_ACROSS_VAL)
            begin
                w_value_reg <= val_sat;
                w_dr_reg    <= slope_sat;
            end
            else
            begin
                w_dz_reg <= val_sat;
            end
        end
    end

    // ------------------------------------------------------- output register
    logic signed [CW-1:0]               out_value_reg;
    logic signed [CW-1:0]               out_dz_reg;
    logic signed [CW-1:0]               out_dr_reg;
    logic signed [CW-1:0]               out_picked_reg;
    logic                               out_oor_reg;
    logic [15:0]                        out_tag_reg;
    logic signed [CW-1:0]               picked_sel;

    always_comb
    begin
        case (pick_reg)
            bgi_pkg::PICK_VALUE:   picked_sel = w_value_reg;
            bgi_pkg::PICK_DERIV_Z: picked_sel = w_dz_reg;
            bgi_pkg::PICK_DERIV_R: picked_sel = w_dr_reg;
            default:               picked_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            // outside the valid cells the value, derivatives and picked result read zero
            out_value_reg  <= oor_reg ? '0 : w_value_reg;
            out_dz_reg     <= oor_reg ? '0 : w_dz_reg;
            out_dr_reg     <= oor_reg ? '0 : w_dr_reg;
            out_picked_reg <= oor_reg ? '0 : picked_sel;
            out_oor_reg    <= oor_reg;
            out_tag_reg    <= tag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tag_reg, out_picked_reg, out_dr_reg, out_dz_reg, out_value_reg};
    assign m_axis_tuser  = out_oor_reg;

    // ------------------------------------------------------------ assertions
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[4*CW-1:0] == '0)
        else $error("out of range result carries non-zero data");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == bgi_pkg::OP_QUERY)
        |=> !s_axis_tready)
        else $error("input reopened straight after a query");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgi_pkg::ST_READ |-> cnt_reg <= bgi_pkg::READ_LAST)
        else $error("read counter ran past the neighbourhood");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgi_pkg::ST_FIT_SUM |-> phase_reg <= bgi_pkg::PHASE_LAST)
        else $error("fit phase ran past the last fit");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
